// ===== rtl/rftnt_pkg.sv =====
// shared types and constants for the trusted node replay filter
package rftnt_pkg;

   localparam int ADDR_W         = 64;
   localparam int FRAME_CNT_W    = 32;
   localparam int KEY_CNT_W      = 8;
   localparam int ENTRIES_USED_W = 4;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 1;

   localparam logic [FRAME_CNT_W-1:0] FRAME_CNT_ALL_ONES = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_ENABLE = 1'd0,
      CSR_ALLOW_NEW_BC  = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      REASON_OK             = 3'd0,
      REASON_UNKNOWN_ORIGIN = 3'd1,
      REASON_REPLAY         = 3'd2,
      REASON_BARRED_BC      = 3'd3,
      REASON_AUTH_FAILED    = 3'd4
   } reason_type;

   typedef struct packed {
      logic [ADDR_W-1:0]      node_address;
      logic [FRAME_CNT_W-1:0] node_frame_count;
      logic [KEY_CNT_W-1:0]   node_key_count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic equal;
      logic greater;
   } cmp_result_type;

endpackage

// ===== rtl/rftnt_ram.sv =====
// generic single-port-write, registered-read ram
module rftnt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rftnt_cmp.sv =====
// shared 64-bit equality and magnitude compare unit
module rftnt_cmp (
   input  logic [rftnt_pkg::ADDR_W-1:0] op_a,
   input  logic [rftnt_pkg::ADDR_W-1:0] op_b,
   output rftnt_pkg::cmp_result_type    result
);

   always_comb begin
      result.equal   = (op_a == op_b);
      result.greater = (op_a > op_b);
   end

endmodule

// ===== rtl/replay_filter_trusted_node_table.sv =====
// top level of the trusted node replay filter
//
// usage:
//   an item transfers at a rising edge with start high and busy low; the
//   req_ ports carry one received frame's security facts. exactly one
//   result per item appears on the rsp_ ports for a single cycle, marked
//   by rsp_valid; the receiver cannot stall and must take it then.
//   csr_we writes csr_wdata to register csr_index (0 filter enable, 1 allow new entries
//   from broadcast targets); the user must write only while the block is idle, unchecked by it.
// flow:
//   unsecured frames, unfiltered frames and broadcast origins answer in the
//   cycle after the transfer and busy never rises. filtered frames walk
//   the table through one shared compare unit, one entry per cycle off
//   the table ram's registered read port: a hit goes on from ST_SCAN to
//   ST_CHECK, a miss from ST_SCAN to ST_MISS (straight to ST_MISS with an
//   empty table). no new item is taken while busy is high.
// reset:
//   clears both registers and the entry count; table contents are not
//   cleared, entries above the count are never read.
module replay_filter_trusted_node_table #(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            start,
   output logic                                            busy,
   input  logic                                            req_secured,
   input  logic                                            req_counter_present,
   input  logic                                            req_origin_broadcast,
   input  logic [rftnt_pkg::ADDR_W-1:0]                    req_origin_address,
   input  logic [rftnt_pkg::FRAME_CNT_W-1:0]               req_frame_cnt,
   input  logic [rftnt_pkg::KEY_CNT_W-1:0]                 req_key_cnt,
   input  logic                                            req_target_broadcast,
   input  logic                                            req_auth_ok,
   output logic                                            rsp_valid,
   output logic                                            rsp_accepted,
   output logic [2:0]                                      rsp_reason,
   output logic                                            rsp_add_failed_full,
   output logic [rftnt_pkg::ENTRIES_USED_W-1:0]            rsp_entries_used,
   input  logic                                            csr_we,
   input  logic [rftnt_pkg::CSR_INDEX_W-1:0]               csr_index,
   input  logic [rftnt_pkg::CSR_DATA_W-1:0]                csr_wdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_MISS
   } state_type;

   state_type state_ff, state_in;

   logic filter_enable_ff, filter_enable_in;
   logic allow_new_bc_ff, allow_new_bc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [rftnt_pkg::ADDR_W-1:0]      addr_ff, addr_in;
   logic [rftnt_pkg::FRAME_CNT_W-1:0] fc_ff, fc_in;
   logic [rftnt_pkg::KEY_CNT_W-1:0]   kc_ff, kc_in;
   logic                              tgt_bc_ff, tgt_bc_in;
   logic                              auth_ff, auth_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_accepted_ff, rsp_accepted_in;
   rftnt_pkg::reason_type                  rsp_reason_ff, rsp_reason_in;
   logic                                   rsp_full_ff, rsp_full_in;
   logic [rftnt_pkg::ENTRIES_USED_W-1:0]   rsp_used_ff, rsp_used_in;

   logic                          ram_wr_en;
   logic [IDX_W-1:0]              ram_wr_addr;
   rftnt_pkg::entry_type          ram_wr_data;
   logic                          ram_rd_en;
   logic [IDX_W-1:0]              ram_rd_addr;
   rftnt_pkg::entry_type          ram_rd_data;

   logic [rftnt_pkg::ADDR_W-1:0]  cmp_a;
   logic [rftnt_pkg::ADDR_W-1:0]  cmp_b;
   rftnt_pkg::cmp_result_type     cmp_res;

   logic last_entry;

   rftnt_ram #(
      .WIDTH (rftnt_pkg::ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rftnt_cmp u_cmp (
      .op_a   (cmp_a),
      .op_b   (cmp_b),
      .result (cmp_res)
   );

   // compare unit serves the address search and then the counter check
   always_comb begin
      if (state_ff == ST_CHECK) begin
         cmp_a = {{(rftnt_pkg::ADDR_W - rftnt_pkg::FRAME_CNT_W){1'b0}},
                  ram_rd_data.node_frame_count};
         cmp_b = {{(rftnt_pkg::ADDR_W - rftnt_pkg::FRAME_CNT_W){1'b0}}, fc_ff};
      end else begin
         cmp_a = ram_rd_data.node_address;
         cmp_b = addr_ff;
      end
   end

   assign last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in         = state_ff;
      filter_enable_in = filter_enable_ff;
      allow_new_bc_in  = allow_new_bc_ff;
      count_in         = count_ff;
      idx_in           = idx_ff;
      addr_in          = addr_ff;
      fc_in            = fc_ff;
      kc_in            = kc_ff;
      tgt_bc_in        = tgt_bc_ff;
      auth_in          = auth_ff;
      rsp_valid_in     = 1'b0;
      rsp_accepted_in  = rsp_accepted_ff;
      rsp_reason_in    = rsp_reason_ff;
      rsp_full_in      = rsp_full_ff;
      rsp_used_in      = rsp_used_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = idx_ff;
      ram_wr_data      = '{node_address: addr_ff, node_frame_count: fc_ff,
                           node_key_count: ram_rd_data.node_key_count};
      ram_rd_en        = 1'b0;
      ram_rd_addr      = idx_ff + IDX_W'(1);

      if (csr_we) begin
         case (csr_index)
            rftnt_pkg::CSR_FILTER_ENABLE: filter_enable_in = csr_wdata[0];
            rftnt_pkg::CSR_ALLOW_NEW_BC:  allow_new_bc_in  = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               addr_in   = req_origin_address;
               fc_in     = req_frame_cnt;
               kc_in     = req_key_cnt;
               tgt_bc_in = req_target_broadcast;
               auth_in   = req_auth_ok;
               rsp_full_in = 1'b0;
               rsp_used_in = rftnt_pkg::ENTRIES_USED_W'(count_ff);
               if (!req_secured) begin
                  rsp_valid_in    = 1'b1;
                  rsp_accepted_in = 1'b1;
                  rsp_reason_in   = rftnt_pkg::REASON_OK;
               end else if (req_counter_present && filter_enable_ff) begin
                  if (req_origin_broadcast) begin
                     rsp_valid_in    = 1'b1;
                     rsp_accepted_in = 1'b0;
                     rsp_reason_in   = rftnt_pkg::REASON_UNKNOWN_ORIGIN;
                  end else if (count_ff == '0) begin
                     state_in = ST_MISS;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     idx_in      = '0;
                     state_in    = ST_SCAN;
                  end
               end else begin
                  rsp_valid_in    = 1'b1;
                  rsp_accepted_in = req_auth_ok;
                  rsp_reason_in   = req_auth_ok ? rftnt_pkg::REASON_OK
                                                : rftnt_pkg::REASON_AUTH_FAILED;
               end
            end
         end

         ST_SCAN: begin
            // read data belongs to entry idx_ff; the next read goes out now unless it hit or was the last
            if (cmp_res.equal) begin
               state_in = ST_CHECK;
            end else if (last_entry) begin
               state_in = ST_MISS;
            end else begin
               ram_rd_en = 1'b1;
               idx_in    = idx_ff + IDX_W'(1);
            end
         end

         ST_CHECK: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (cmp_res.greater ||
                ram_rd_data.node_frame_count == rftnt_pkg::FRAME_CNT_ALL_ONES) begin
               rsp_accepted_in = 1'b0;
               rsp_reason_in   = rftnt_pkg::REASON_REPLAY;
            end else begin
               // counter moves on even if authentication then fails
               ram_wr_en       = 1'b1;
               rsp_accepted_in = auth_ff;
               rsp_reason_in   = auth_ff ? rftnt_pkg::REASON_OK
                                         : rftnt_pkg::REASON_AUTH_FAILED;
            end
         end

         ST_MISS: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (tgt_bc_ff && !allow_new_bc_ff) begin
               rsp_accepted_in = 1'b0;
               rsp_reason_in   = rftnt_pkg::REASON_BARRED_BC;
            end else if (!auth_ff) begin
               rsp_accepted_in = 1'b0;
               rsp_reason_in   = rftnt_pkg::REASON_AUTH_FAILED;
            end else begin
               rsp_accepted_in = 1'b1;
               rsp_reason_in   = rftnt_pkg::REASON_OK;
               if (count_ff < CNT_FULL) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = count_ff[IDX_W-1:0];
                  ram_wr_data = '{node_address: addr_ff, node_frame_count: fc_ff,
                                  node_key_count: kc_ff};
                  count_in    = count_ff + CNT_W'(1);
                  rsp_used_in = rftnt_pkg::ENTRIES_USED_W'(count_ff + CNT_W'(1));
               end else begin
                  rsp_full_in = 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         filter_enable_ff <= 1'b0;
         allow_new_bc_ff  <= 1'b0;
         count_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         filter_enable_ff <= filter_enable_in;
         allow_new_bc_ff  <= allow_new_bc_in;
         count_ff         <= count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      idx_ff          <= idx_in;
      addr_ff         <= addr_in;
      fc_ff           <= fc_in;
      kc_ff           <= kc_in;
      tgt_bc_ff       <= tgt_bc_in;
      auth_ff         <= auth_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_reason_ff   <= rsp_reason_in;
      rsp_full_ff     <= rsp_full_in;
      rsp_used_ff     <= rsp_used_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_accepted_ff;
   assign rsp_reason          = rsp_reason_ff;
   assign rsp_add_failed_full = rsp_full_ff;
   assign rsp_entries_used    = rsp_used_ff;

`ifndef NO_ASSERTIONS
   a_rsp_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while the table walk is still running");

   a_reject_has_reason : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (rsp_reason != rftnt_pkg::REASON_OK))
      else $error("rejected frame carries the ok reason");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count beyond table size");

   a_count_moves_on_accept : assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (rsp_valid && rsp_accepted && !rsp_add_failed_full))
      else $error("entry count changed without an accepted new node");
`endif

endmodule

// ===== tb/replay_filter_trusted_node_table_tb.sv =====
// self-checking testbench for the trusted node replay filter
module replay_filter_trusted_node_table_tb;

   localparam int NODES       = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RAND_PHASES = 10;
   localparam int PHASE_ITEMS = 105;

   typedef struct {
      bit                                secured;
      bit                                counter_present;
      bit                                origin_broadcast;
      logic [rftnt_pkg::ADDR_W-1:0]      origin_address;
      logic [rftnt_pkg::FRAME_CNT_W-1:0] frame_cnt;
      logic [rftnt_pkg::KEY_CNT_W-1:0]   key_cnt;
      bit                                target_broadcast;
      bit                                auth_ok;
   } frame_type;

   typedef struct {
      bit                                   accepted;
      rftnt_pkg::reason_type                reason;
      bit                                   full;
      logic [rftnt_pkg::ENTRIES_USED_W-1:0] used;
   } verdict_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic                                 req_secured;
   logic                                 req_counter_present;
   logic                                 req_origin_broadcast;
   logic [rftnt_pkg::ADDR_W-1:0]         req_origin_address;
   logic [rftnt_pkg::FRAME_CNT_W-1:0]    req_frame_cnt;
   logic [rftnt_pkg::KEY_CNT_W-1:0]      req_key_cnt;
   logic                                 req_target_broadcast;
   logic                                 req_auth_ok;
   logic                                 rsp_valid;
   logic                                 rsp_accepted;
   logic [2:0]                           rsp_reason;
   logic                                 rsp_add_failed_full;
   logic [rftnt_pkg::ENTRIES_USED_W-1:0] rsp_entries_used;
   logic                                 csr_we;
   logic [rftnt_pkg::CSR_INDEX_W-1:0]    csr_index;
   logic [rftnt_pkg::CSR_DATA_W-1:0]     csr_wdata;

   // shadow of the block's registers and trusted node table
   bit                                filter_on;
   bit                                allow_bc_new;
   logic [rftnt_pkg::ADDR_W-1:0]      trusted_addr [NODES];
   logic [rftnt_pkg::FRAME_CNT_W-1:0] trusted_fc   [NODES];
   logic [rftnt_pkg::KEY_CNT_W-1:0]   trusted_kc   [NODES];
   int                                trusted_count;

   verdict_type verdict_q[$];
   int          errors;
   int          cycles;

   replay_filter_trusted_node_table #(
      .TABLE_ENTRIES(NODES)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_secured          (req_secured),
      .req_counter_present  (req_counter_present),
      .req_origin_broadcast (req_origin_broadcast),
      .req_origin_address   (req_origin_address),
      .req_frame_cnt        (req_frame_cnt),
      .req_key_cnt          (req_key_cnt),
      .req_target_broadcast (req_target_broadcast),
      .req_auth_ok          (req_auth_ok),
      .rsp_valid            (rsp_valid),
      .rsp_accepted         (rsp_accepted),
      .rsp_reason           (rsp_reason),
      .rsp_add_failed_full  (rsp_add_failed_full),
      .rsp_entries_used     (rsp_entries_used),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // works out the filter verdict and updates the shadow table
   function automatic verdict_type filter_verdict(frame_type f);
      verdict_type v;
      int          hit;
      bit          create;
      v      = '{accepted: 1'b1, reason: rftnt_pkg::REASON_OK, full: 1'b0, used: '0};
      hit    = -1;
      create = 1'b0;
      if (f.secured) begin
         if (f.counter_present && filter_on) begin
            if (f.origin_broadcast) begin
               v.accepted = 1'b0;
               v.reason   = rftnt_pkg::REASON_UNKNOWN_ORIGIN;
            end else begin
               for (int i = 0; i < trusted_count; i++)
                  if (hit < 0 && trusted_addr[i] == f.origin_address) hit = i;
               if (hit >= 0) begin
                  if (trusted_fc[hit] > f.frame_cnt ||
                      trusted_fc[hit] == rftnt_pkg::FRAME_CNT_ALL_ONES) begin
                     v.accepted = 1'b0;
                     v.reason   = rftnt_pkg::REASON_REPLAY;
                  end else begin
                     // counter moves on even if authentication later fails
                     trusted_fc[hit] = f.frame_cnt;
                  end
               end else if (f.target_broadcast && !allow_bc_new) begin
                  v.accepted = 1'b0;
                  v.reason   = rftnt_pkg::REASON_BARRED_BC;
               end else begin
                  create = 1'b1;
               end
            end
         end
         if (v.accepted && !f.auth_ok) begin
            v.accepted = 1'b0;
            v.reason   = rftnt_pkg::REASON_AUTH_FAILED;
         end else if (v.accepted && create) begin
            if (trusted_count < NODES) begin
               trusted_addr[trusted_count] = f.origin_address;
               trusted_fc[trusted_count]   = f.frame_cnt;
               trusted_kc[trusted_count]   = f.key_cnt;
               trusted_count++;
            end else begin
               v.full = 1'b1;
            end
         end
      end
      v.used = trusted_count[rftnt_pkg::ENTRIES_USED_W-1:0];
      return v;
   endfunction

   function automatic frame_type frame_of(bit sec, bit cnt, bit obc,
                                          logic [rftnt_pkg::ADDR_W-1:0] addr,
                                          logic [rftnt_pkg::FRAME_CNT_W-1:0] fc,
                                          logic [rftnt_pkg::KEY_CNT_W-1:0] kc,
                                          bit tbc, bit auth);
      frame_type f;
      f.secured          = sec;
      f.counter_present  = cnt;
      f.origin_broadcast = obc;
      f.origin_address   = addr;
      f.frame_cnt        = fc;
      f.key_cnt          = kc;
      f.target_broadcast = tbc;
      f.auth_ok          = auth;
      return f;
   endfunction

   // mostly well-formed secured frames from known nodes, with some noise
   function automatic frame_type random_frame();
      frame_type f;
      int        r;
      int        q;
      int        idx;
      r = $urandom_range(99);
      f = frame_of(1'b1, 1'b1, 1'b0, {$urandom, $urandom}, $urandom, 8'($urandom),
                   $urandom_range(3) == 0, $urandom_range(9) != 0);
      if (r < 55 && trusted_count > 0) begin
         idx              = $urandom_range(trusted_count - 1);
         f.origin_address = trusted_addr[idx];
         q                = $urandom_range(49);
         if (q == 0)
            f.frame_cnt = rftnt_pkg::FRAME_CNT_ALL_ONES;
         else if (q < 5)
            f.frame_cnt = trusted_fc[idx] - 1 - $urandom_range(3);
         else if (q >= 7)
            f.frame_cnt = trusted_fc[idx] + $urandom_range(4);
      end else if (r >= 75 && r < 82) begin
         f.counter_present = 1'b0;
      end else if (r >= 82 && r < 88) begin
         f.origin_broadcast = 1'b1;
      end else if (r >= 88 && r < 94) begin
         f.secured          = 1'b0;
         f.counter_present  = 1'($urandom_range(1));
         f.origin_broadcast = 1'($urandom_range(1));
      end else if (r >= 94) begin
         f.secured          = 1'($urandom_range(1));
         f.counter_present  = 1'($urandom_range(1));
         f.origin_broadcast = 1'($urandom_range(1));
         f.target_broadcast = 1'($urandom_range(1));
         f.auth_ok          = 1'($urandom_range(1));
      end
      return f;
   endfunction

   task automatic report_failure(string what, verdict_type e, bit with_exp);
      errors++;
      if (errors <= 10) begin
         if (with_exp)
            $display("%s: expected acc=%0b reason=%0d full=%0b used=%0d", what,
                     e.accepted, e.reason, e.full, e.used);
         $display("%s: got acc=%0b reason=%0d full=%0b used=%0d at cycle %0d", what,
                  rsp_accepted, rsp_reason, rsp_add_failed_full, rsp_entries_used, cycles);
      end
   endtask

   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp_valid === 1'b1) begin
         if (verdict_q.size() == 0) begin
            report_failure("unexpected result", e, 1'b0);
         end else begin
            e = verdict_q.pop_front();
            if (rsp_accepted !== e.accepted || rsp_reason !== e.reason ||
                rsp_add_failed_full !== e.full || rsp_entries_used !== e.used)
               report_failure("mismatch", e, 1'b1);
         end
      end
   end

   // start is left high after a transfer so that bursts run back to back
   task automatic send_frame(frame_type f);
      @(negedge clock);
      req_secured          = f.secured;
      req_counter_present  = f.counter_present;
      req_origin_broadcast = f.origin_broadcast;
      req_origin_address   = f.origin_address;
      req_frame_cnt        = f.frame_cnt;
      req_key_cnt          = f.key_cnt;
      req_target_broadcast = f.target_broadcast;
      req_auth_ok          = f.auth_ok;
      start                = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      verdict_q.push_back(filter_verdict(f));
   endtask

   task automatic pause(int n);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      pause(1);
      while (verdict_q.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(rftnt_pkg::csr_index_type idx, bit value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == rftnt_pkg::CSR_FILTER_ENABLE) filter_on = value;
      else allow_bc_new = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_mode(bit filt, bit allow_bc);
      drain();
      csr_write(rftnt_pkg::CSR_FILTER_ENABLE, filt);
      csr_write(rftnt_pkg::CSR_ALLOW_NEW_BC, allow_bc);
   endtask

   // filter off: only the secured flag and authentication count
   task automatic test_unfiltered();
      set_mode(1'b0, 1'b0);
      send_frame(frame_of(1'b0, 1'b1, 1'b1, '1, '1, '1, 1'b1, 1'b0));
      send_frame(frame_of(1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0));
      send_frame(frame_of(1'b1, 1'b1, 1'b0, 64'h0123_4567_89AB_CDEF, 32'd9, 8'd1,
                          1'b1, 1'b1));
   endtask

   task automatic test_filter_basics();
      logic [rftnt_pkg::ADDR_W-1:0] a;
      a = 64'h0123_4567_89AB_CDEF;
      set_mode(1'b1, 1'b0);
      send_frame(frame_of(1'b1, 1'b1, 1'b1, a, 32'd5, 8'd0, 1'b0, 1'b1));
      send_frame(frame_of(1'b1, 1'b1, 1'b0, a, 32'd5, 8'd0, 1'b1, 1'b1));
      send_frame(frame_of(1'b1, 1'b1, 1'b0, a, 32'd5, 8'd0, 1'b0, 1'b0));
      send_frame(frame_of(1'b1, 1'b1, 1'b0, a, 32'd5, 8'h5A, 1'b0, 1'b1));
      send_frame(frame_of(1'b1, 1'b1, 1'b0, a, 32'd3, 8'd0, 1'b0, 1'b1));
      send_frame(frame_of(1'b1, 1'b1, 1'b0, a, 32'd5, 8'd7, 1'b0, 1'b1));
      // known node failing authentication keeps its new counter
      send_frame(frame_of(1'b1, 1'b1, 1'b0, a, 32'd9, 8'd0, 1'b0, 1'b0));
      send_frame(frame_of(1'b1, 1'b1, 1'b0, a, 32'd8, 8'd0, 1'b0, 1'b1));
      send_frame(frame_of(1'b1, 1'b1, 1'b0, '1, '1, '1, 1'b0, 1'b1));
      send_frame(frame_of(1'b1, 1'b1, 1'b0, '1, '1, '0, 1'b0, 1'b1));
      send_frame(frame_of(1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b1));
      send_frame(frame_of(1'b1, 1'b0, 1'b0, 64'h5555_AAAA_5555_AAAA, '1, 8'hA5,
                          1'b1, 1'b1));
   endtask

   task automatic test_table_fill();
      set_mode(1'b1, 1'b1);
      send_frame(frame_of(1'b1, 1'b1, 1'b0, 64'hAAAA_5555_AAAA_5555, 32'h8000_0000,
                          8'h80, 1'b1, 1'b1));
      repeat (4)
         send_frame(frame_of(1'b1, 1'b1, 1'b0, {$urandom, $urandom}, $urandom,
                             8'($urandom), 1'($urandom_range(1)), 1'b1));
      // table is full now: accepted but flagged
      send_frame(frame_of(1'b1, 1'b1, 1'b0, 64'hFEDC_BA98_7654_3210, 32'd1, 8'd2,
                          1'b1, 1'b1));
      send_frame(frame_of(1'b1, 1'b1, 1'b0, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFE, 8'd0,
                          1'b0, 1'b1));
   endtask

   task automatic test_random_traffic();
      int burst_left;
      bit calm;
      burst_left = 0;
      for (int p = 0; p < RAND_PHASES; p++) begin
         set_mode(p % 4 != 2, p % 4 == 1 || p % 4 == 2);
         calm = (p % 3 == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 8);
               if (!calm) pause($urandom_range(6));
            end
            burst_left--;
            send_frame(random_frame());
         end
      end
   endtask

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      start                = 1'b0;
      req_secured          = 1'b0;
      req_counter_present  = 1'b0;
      req_origin_broadcast = 1'b0;
      req_origin_address   = '0;
      req_frame_cnt        = '0;
      req_key_cnt          = '0;
      req_target_broadcast = 1'b0;
      req_auth_ok          = 1'b0;
      csr_we               = 1'b0;
      csr_index            = rftnt_pkg::CSR_FILTER_ENABLE;
      csr_wdata            = '0;
      filter_on            = 1'b0;
      allow_bc_new         = 1'b0;
      trusted_count        = 0;
      errors               = 0;
      cycles               = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_unfiltered();
      test_filter_basics();
      test_table_fill();
      test_random_traffic();

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
